// File: hdl/time_window_min_max_mean_unit_defines.svh
// Assertion macros shared by the checker file of the windowed min/max/mean unit.
`ifndef TIME_WINDOW_MIN_MAX_MEAN_UNIT_DEFINES_SVH
`define TIME_WINDOW_MIN_MAX_MEAN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TWMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TWMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/twmm_pkg.sv
// Types and constants of the windowed min/max/mean unit.
package twmm_pkg;

  localparam int TIME_W     = 32;
  localparam int VAL_W      = 32;
  localparam int IN_DATA_W  = TIME_W + VAL_W;
  localparam int OUT_DATA_W = 3 * VAL_W;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Bit positions in the result tuser.
  localparam int USER_ANY = 0;
  localparam int USER_OVF = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_START = 1'b0,
    REG_WINDOW_END   = 1'b1
  } cfg_reg_t;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_CMP_LO  = 12'b0000_0000_0010,
    ST_CMP_HI  = 12'b0000_0000_0100,
    ST_ADD     = 12'b0000_0000_1000,
    ST_CMP_MIN = 12'b0000_0001_0000,
    ST_CMP_MAX = 12'b0000_0010_0000,
    ST_FINISH  = 12'b0000_0100_0000,
    ST_ABS     = 12'b0000_1000_0000,
    ST_PREP    = 12'b0001_0000_0000,
    ST_DIV     = 12'b0010_0000_0000,
    ST_NEG     = 12'b0100_0000_0000,
    ST_LOAD    = 12'b1000_0000_0000
  } state_t;

endpackage

// File: hdl/time_window_min_max_mean_unit.sv
// Windowed min/max/mean over a batch of timestamped samples, one shared adder.
//
//  channel | dir | handshake                 | payload
//  s_      | in  | s_tvalid / s_tready       | s_tdata: sample_time, sample_value; s_tlast
//  m_      | out | m_tvalid / m_tready       | m_tdata: max, min, mean; m_tuser: flags
//  cfg_    | in  | cfg_wen (no back-pressure)| cfg_index, cfg_data
//
// Every step runs through one 50-bit add/subtract unit (SUM_W+1 bits), one use a cycle.
// Sample outside the window or dropped: IDLE, CMP_LO, CMP_HI and FINISH before the next
// acceptance; counted sample: also ADD, CMP_MIN and CMP_MAX. After the last sample the mean runs
// through ABS, PREP, a restoring divide (one quotient bit a cycle) and NEG before LOAD when anything
// was counted, else FINISH goes straight to LOAD.
// A finished result sits in the output register; the unit only waits when a new result
// is ready while the previous one is still stalled. Reset is synchronous on rst.
module time_window_min_max_mean_unit #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [twmm_pkg::IN_DATA_W-1:0]      s_tdata,   // sample_time, sample_value
  input  logic                                s_tlast,   // last_sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [twmm_pkg::OUT_DATA_W-1:0]     m_tdata,   // max_value, min_value, mean_value
  output logic [twmm_pkg::OUT_USER_W-1:0]     m_tuser,   // any_counted, overflowed
  input  logic                                cfg_wen,
  input  logic [twmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twmm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import twmm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = VAL_W + CNT_W;
  localparam int ALU_W  = SUM_W + 1;
  localparam int DEN_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_SAMPLES);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  state_t                    state;
  logic [TIME_W-1:0]         window_start;
  logic [TIME_W-1:0]         window_end;
  logic [TIME_W-1:0]         sample_time;
  logic signed [VAL_W-1:0]   sample_value;
  logic                      sample_last;
  logic                      in_lo;
  logic [CNT_W-1:0]          count;
  logic signed [SUM_W-1:0]   sum;
  logic signed [VAL_W-1:0]   run_min;
  logic signed [VAL_W-1:0]   run_max;
  logic                      ovf;
  logic                      sum_neg;
  logic [SUM_W-1:0]          num;
  logic [DEN_W-1:0]          rem;
  logic [DEN_W-1:0]          den;
  logic [STEP_W-1:0]         step;

  logic [ALU_W-1:0]          alu_a;
  logic [ALU_W-1:0]          alu_b;
  logic                      alu_sub;
  logic [ALU_W-1:0]          alu_y;
  logic                      alu_neg;

  assign s_tready = (state == ST_IDLE) && !rst;

  // Operand select for the shared add/subtract unit.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state)
      ST_CMP_LO: begin
        alu_a = ALU_W'(sample_time);
        alu_b = ALU_W'(window_start);
      end
      ST_CMP_HI: begin
        alu_a = ALU_W'(window_end);
        alu_b = ALU_W'(sample_time);
      end
      ST_ADD: begin
        alu_a   = ALU_W'(sum);
        alu_b   = ALU_W'(sample_value);
        alu_sub = 1'b0;
      end
      ST_CMP_MIN: begin
        alu_a = ALU_W'(sample_value);
        alu_b = ALU_W'(run_min);
      end
      ST_CMP_MAX: begin
        alu_a = ALU_W'(run_max);
        alu_b = ALU_W'(sample_value);
      end
      ST_ABS: begin
        alu_b = ALU_W'(sum);
      end
      ST_PREP: begin
        alu_a   = {num, 1'b0};
        alu_b   = ALU_W'(count);
        alu_sub = 1'b0;
      end
      ST_DIV: begin
        alu_a = ALU_W'({rem, num[SUM_W-1]});
        alu_b = ALU_W'(den);
      end
      ST_NEG: begin
        alu_b = ALU_W'(num[VAL_W-1:0]);
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_y   = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);
  assign alu_neg = alu_y[ALU_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_start <= '0;
      window_end   <= '1;
      count        <= '0;
      sum          <= '0;
      run_min      <= '0;
      run_max      <= '0;
      ovf          <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_START: window_start <= cfg_data;
          REG_WINDOW_END:   window_end   <= cfg_data;
          default: ;
        endcase
      end

      if (state == ST_LOAD && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            sample_time  <= s_tdata[TIME_W-1:0];
            sample_value <= s_tdata[IN_DATA_W-1:TIME_W];
            sample_last  <= s_tlast;
            state        <= ST_CMP_LO;
          end
        end
        ST_CMP_LO: begin
          in_lo <= !alu_neg;
          state <= ST_CMP_HI;
        end
        ST_CMP_HI: begin
          if (in_lo && !alu_neg) begin
            if (count == CNT_FULL) begin
              ovf   <= 1'b1;
              state <= ST_FINISH;
            end else begin
              state <= ST_ADD;
            end
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_ADD: begin
          sum   <= alu_y[SUM_W-1:0];
          state <= ST_CMP_MIN;
        end
        ST_CMP_MIN: begin
          if (count == '0 || alu_neg) begin
            run_min <= sample_value;
          end
          state <= ST_CMP_MAX;
        end
        ST_CMP_MAX: begin
          if (count == '0 || alu_neg) begin
            run_max <= sample_value;
          end
          count <= count + CNT_W'(1);
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!sample_last) begin
            state <= ST_IDLE;
          end else if (count == '0) begin
            state <= ST_LOAD;
          end else begin
            state <= ST_ABS;
          end
        end
        ST_ABS: begin
          // Take the magnitude of the sum; round on it, restore the sign at the end.
          sum_neg <= sum[SUM_W-1];
          num     <= sum[SUM_W-1] ? alu_y[SUM_W-1:0] : sum;
          state   <= ST_PREP;
        end
        ST_PREP: begin
          // Divide (2*|sum| + count) by 2*count: round to nearest, ties away from zero.
          num   <= alu_y[SUM_W-1:0];
          den   <= {count, 1'b0};
          rem   <= '0;
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (!alu_neg) begin
            rem <= alu_y[DEN_W-1:0];
          end else begin
            rem <= {rem[DEN_W-2:0], num[SUM_W-1]};
          end
          num  <= {num[SUM_W-2:0], !alu_neg};
          step <= step + STEP_W'(1);
          if (step == STEP_LAST) begin
            state <= ST_NEG;
          end
        end
        ST_NEG: begin
          if (sum_neg) begin
            num <= {num[SUM_W-1:VAL_W], alu_y[VAL_W-1:0]};
          end
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          // Hold until the output register is free, then clear the batch.
          if (!m_tvalid || m_tready) begin
            m_tuser[USER_ANY]  <= (count != '0);
            m_tuser[USER_OVF]  <= ovf;
            if (count != '0) begin
              m_tdata <= {num[VAL_W-1:0], run_min, run_max};
            end else begin
              m_tdata <= '0;
            end
            count   <= '0;
            sum     <= '0;
            run_min <= '0;
            run_max <= '0;
            ovf     <= 1'b0;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/twmm_checker.sv
// Port-level checks of the windowed min/max/mean unit and their bind.
`include "time_window_min_max_mean_unit_defines.svh"

module twmm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [twmm_pkg::OUT_DATA_W-1:0]     m_tdata,   // max_value, min_value, mean_value
  input logic [twmm_pkg::OUT_USER_W-1:0]     m_tuser    // any_counted, overflowed
);
  import twmm_pkg::*;

  logic signed [VAL_W-1:0] max_v;
  logic signed [VAL_W-1:0] min_v;
  logic signed [VAL_W-1:0] mean_v;

  assign max_v  = m_tdata[VAL_W-1:0];
  assign min_v  = m_tdata[2*VAL_W-1:VAL_W];
  assign mean_v = m_tdata[3*VAL_W-1:2*VAL_W];

  `TWMM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `TWMM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after an accepted item")
  `TWMM_ASSERT_NOW(a_none_zero, m_tvalid && !m_tuser[USER_ANY], m_tdata == '0, "empty batch with nonzero data")
  `TWMM_ASSERT_NOW(a_min_le_max, m_tvalid && m_tuser[USER_ANY], min_v <= max_v, "min above max")
  `TWMM_ASSERT_NOW(a_mean_range, m_tvalid && m_tuser[USER_ANY], mean_v >= min_v && mean_v <= max_v, "mean outside min..max")

endmodule

bind time_window_min_max_mean_unit twmm_checker u_twmm_checker (.*);
